[rtl/core/wss_pkg.sv]
`default_nettype none
package wss_pkg;

  localparam int OP_W     = 2;
  localparam int SPEC_W   = 2;
  localparam int BIN_W    = 10;
  localparam int WEIGHT_W = 16;
  localparam int FRAC_W   = 16;
  localparam int COUNT_W  = 32;
  localparam int STATUS_W = 2;

  localparam int Q_DEPTH = 2;
  localparam int Q_PW    = 1;
  localparam int Q_CW    = 2;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_DRAW  = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_SAT   = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    B_INIT,
    B_IDLE,
    B_LD_RD,
    B_LD_WR,
    B_MUL_LO,
    B_MUL_HI,
    B_WALK,
    B_HRD,
    B_HWR,
    B_HCLR
  } bstate_t;

  typedef struct packed {
    op_t                 op;
    logic [SPEC_W-1:0]   spec;
    logic [BIN_W-1:0]    bin;
    logic [WEIGHT_W-1:0] weight;
    logic [FRAC_W-1:0]   frac;
    logic                spec_ok;
    logic                bin_ok;
    logic                last_bin;
  } item_t;

endpackage
`default_nettype wire

[rtl/core/wss_front.sv]
`default_nettype none
module wss_front #(
  parameter int BINS    = 1024,
  parameter int SPECTRA = 4
) (
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [wss_pkg::OP_W-1:0]      in_opcode,
  input  wire logic [wss_pkg::SPEC_W-1:0]    in_spectrum_sel,
  input  wire logic [wss_pkg::BIN_W-1:0]     in_bin_sel,
  input  wire logic [wss_pkg::WEIGHT_W-1:0]  in_bin_weight,
  input  wire logic [wss_pkg::FRAC_W-1:0]    in_random_fraction,
  input  wire logic                          q_full,
  input  wire logic                          init_busy,
  output logic                               push,
  output wss_pkg::item_t                     push_item
);
  import wss_pkg::*;

  assign busy = q_full | init_busy;
  assign push = start & ~busy;

  always_comb begin
    push_item.op       = op_t'(in_opcode);
    push_item.spec     = in_spectrum_sel;
    push_item.bin      = in_bin_sel;
    push_item.weight   = in_bin_weight;
    push_item.frac     = in_random_fraction;
    push_item.spec_ok  = 32'(in_spectrum_sel) < 32'(SPECTRA);
    push_item.bin_ok   = 32'(in_bin_sel) < 32'(BINS);
    push_item.last_bin = 32'(in_bin_sel) == 32'(BINS - 1);
  end

endmodule
`default_nettype wire

[rtl/core/wss_queue.sv]
`default_nettype none
module wss_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire wss_pkg::item_t push_item,
  output logic                full,
  input  wire logic           pop,
  output logic                valid,
  output wss_pkg::item_t      head
);
  import wss_pkg::*;

  item_t           mem_r [Q_DEPTH];
  logic [Q_PW-1:0] wr_ptr_r;
  logic [Q_PW-1:0] rd_ptr_r;
  logic [Q_CW-1:0] cnt_r;

  assign full  = cnt_r == Q_CW'(Q_DEPTH);
  assign valid = cnt_r != '0;
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/core/wss_back.sv]
`default_nettype none
module wss_back #(
  parameter int BINS        = 1024,
  parameter int SPECTRA     = 4,
  parameter int WEIGHT_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          q_valid,
  input  wire wss_pkg::item_t                q_item,
  output logic                               q_pop,
  output logic                               init_busy,
  output logic                               out_strobe,
  output logic [wss_pkg::BIN_W-1:0]          out_hit_bin,
  output logic [wss_pkg::COUNT_W-1:0]        out_count_value,
  output logic [wss_pkg::STATUS_W-1:0]       out_status
);
  import wss_pkg::*;

  localparam int BW     = $clog2(BINS);
  localparam int SW     = (SPECTRA > 1) ? $clog2(SPECTRA) : 1;
  localparam int WDEPTH = SPECTRA * BINS;
  localparam int WA     = $clog2(WDEPTH);
  localparam int TW     = WEIGHT_BITS + BW;
  localparam int HALF   = (TW + 1) / 2;
  localparam int PW     = FRAC_W + TW;
  localparam int HW     = PW - HALF;

  // memories
  logic [WEIGHT_BITS-1:0] wt_mem [WDEPTH];
  logic [COUNT_W-1:0]     hist_mem [BINS];

  logic                   wt_we;
  logic [WA-1:0]          wt_waddr, wt_raddr;
  logic [WEIGHT_BITS-1:0] wt_wdata, wt_q;
  logic                   hist_we;
  logic [BW-1:0]          hist_waddr, hist_raddr;
  logic [COUNT_W-1:0]     hist_wdata, hist_q;

  always_ff @(posedge clk) begin
    if (wt_we) begin
      wt_mem[wt_waddr] <= wt_wdata;
    end
    wt_q <= wt_mem[wt_raddr];
  end

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[hist_waddr] <= hist_wdata;
    end
    hist_q <= hist_mem[hist_raddr];
  end

  // control and datapath registers
  bstate_t                 state_r, state_nxt;
  item_t                   cur_r, cur_nxt;
  logic [WA-1:0]           clr_r, clr_nxt;
  logic [BW-1:0]           rd_idx_r, rd_idx_nxt;
  logic [BW-1:0]           cmp_idx_r, cmp_idx_nxt;
  logic                    dv_r, dv_nxt;
  logic [TW-1:0]           left_r, left_nxt;
  logic [TW-1:0]           point_r, point_nxt;
  logic [FRAC_W+HALF-1:0]  p_lo_r, p_lo_nxt;
  logic [BW-1:0]           hit_idx_r, hit_idx_nxt;
  logic [TW-1:0]           total_r [SPECTRA];
  logic                    out_strobe_r;
  logic [BIN_W-1:0]        out_hit_bin_r;
  logic [COUNT_W-1:0]      out_count_value_r;
  status_t                 out_status_r;

  logic                    tot_we;
  logic [TW-1:0]           tot_wdata;
  logic                    emit;
  logic [BIN_W-1:0]        e_bin;
  logic [COUNT_W-1:0]      e_cnt;
  status_t                 e_st;

  logic [SW-1:0]           spec_idx;
  logic [BW-1:0]           bin_idx;
  logic [TW-1:0]           tot_cur;
  logic [WA-1:0]           wt_base;
  logic [WA-1:0]           ld_addr;
  logic                    draw_empty;
  logic [TW:0]             walk_sum;
  logic                    walk_hit;
  logic                    last_cmp;
  logic                    hist_sat;
  logic [HW-1:0]           mul_hi;
  logic [PW-1:0]           prod;
  logic [WEIGHT_BITS-1:0]  ld_weight;

  assign spec_idx   = SW'(cur_r.spec);
  assign bin_idx    = BW'(cur_r.bin);
  assign tot_cur    = total_r[spec_idx];
  assign wt_base    = WA'(spec_idx) * WA'(BINS);
  assign ld_addr    = wt_base + WA'(bin_idx);
  assign draw_empty = !cur_r.spec_ok || (tot_cur == '0);
  assign walk_sum   = (TW+1)'(left_r) + (TW+1)'(wt_q);
  assign walk_hit   = (TW+1)'(point_r) < walk_sum;
  assign last_cmp   = cmp_idx_r == BW'(BINS - 1);
  assign hist_sat   = hist_q == '1;
  assign ld_weight  = cur_r.last_bin ? '0 : WEIGHT_BITS'(cur_r.weight);

  // upper partial product of frac * total; lower half is registered in p_lo_r
  assign mul_hi = HW'(cur_r.frac) * HW'(tot_cur[TW-1:HALF]);
  assign prod   = (PW'(mul_hi) << HALF) + PW'(p_lo_r);

  assign init_busy       = state_r == B_INIT;
  assign out_strobe      = out_strobe_r;
  assign out_hit_bin     = out_hit_bin_r;
  assign out_count_value = out_count_value_r;
  assign out_status      = out_status_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_INIT: begin
        if (clr_r == WA'(WDEPTH - 1)) state_nxt = B_IDLE;
      end
      B_IDLE: begin
        if (q_valid) begin
          unique case (q_item.op)
            OP_LOAD:  state_nxt = B_LD_RD;
            OP_DRAW:  state_nxt = B_MUL_LO;
            OP_READ:  state_nxt = B_HRD;
            OP_CLEAR: state_nxt = B_HCLR;
            default:  state_nxt = B_IDLE;
          endcase
        end
      end
      B_LD_RD:  state_nxt = B_LD_WR;
      B_LD_WR:  state_nxt = B_IDLE;
      B_MUL_LO: state_nxt = draw_empty ? B_IDLE : B_MUL_HI;
      B_MUL_HI: state_nxt = B_WALK;
      B_WALK: begin
        if (dv_r) begin
          if (walk_hit) begin
            state_nxt = B_HRD;
          end else if (last_cmp) begin
            state_nxt = B_IDLE;
          end
        end
      end
      B_HRD: state_nxt = B_HWR;
      B_HWR: state_nxt = B_IDLE;
      B_HCLR: begin
        if (clr_r == WA'(BINS - 1)) state_nxt = B_IDLE;
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    q_pop       = 1'b0;
    cur_nxt     = cur_r;
    clr_nxt     = clr_r;
    rd_idx_nxt  = rd_idx_r;
    cmp_idx_nxt = cmp_idx_r;
    dv_nxt      = dv_r;
    left_nxt    = left_r;
    point_nxt   = point_r;
    p_lo_nxt    = p_lo_r;
    hit_idx_nxt = hit_idx_r;
    wt_we       = 1'b0;
    wt_waddr    = ld_addr;
    wt_raddr    = wt_base + WA'(rd_idx_r);
    wt_wdata    = ld_weight;
    hist_we     = 1'b0;
    hist_waddr  = hit_idx_r;
    hist_wdata  = hist_q + 1'b1;
    hist_raddr  = (cur_r.op == OP_DRAW) ? hit_idx_r : bin_idx;
    tot_we      = 1'b0;
    tot_wdata   = tot_cur - TW'(wt_q) + TW'(ld_weight);
    emit        = 1'b0;
    e_bin       = cur_r.bin;
    e_cnt       = '0;
    e_st        = ST_OK;

    unique case (state_r)
      B_INIT: begin
        wt_we      = 1'b1;
        wt_waddr   = clr_r;
        wt_wdata   = '0;
        hist_we    = 1'b1;
        hist_waddr = clr_r[BW-1:0];
        hist_wdata = '0;
        clr_nxt    = clr_r + 1'b1;
      end
      B_IDLE: begin
        q_pop   = q_valid;
        cur_nxt = q_item;
        clr_nxt = '0;
      end
      B_LD_RD: begin
        wt_raddr = ld_addr;
      end
      B_LD_WR: begin
        if (cur_r.spec_ok && cur_r.bin_ok) begin
          wt_we  = 1'b1;
          tot_we = 1'b1;
        end
        emit = 1'b1;
      end
      B_MUL_LO: begin
        p_lo_nxt = (FRAC_W+HALF)'(cur_r.frac) * (FRAC_W+HALF)'(tot_cur[HALF-1:0]);
        if (draw_empty) begin
          emit  = 1'b1;
          e_bin = '0;
          e_st  = ST_EMPTY;
        end
      end
      B_MUL_HI: begin
        point_nxt  = prod[PW-1:FRAC_W];
        left_nxt   = '0;
        rd_idx_nxt = '0;
        dv_nxt     = 1'b0;
      end
      B_WALK: begin
        // read of bin k is issued in the cycle before its compare
        rd_idx_nxt  = (rd_idx_r == BW'(BINS - 1)) ? rd_idx_r : rd_idx_r + 1'b1;
        cmp_idx_nxt = rd_idx_r;
        dv_nxt      = 1'b1;
        if (dv_r) begin
          if (walk_hit) begin
            hit_idx_nxt = cmp_idx_r;
          end else begin
            left_nxt = walk_sum[TW-1:0];
            if (last_cmp) begin
              emit  = 1'b1;
              e_bin = '0;
              e_st  = ST_EMPTY;
            end
          end
        end
      end
      B_HRD: begin
      end
      B_HWR: begin
        emit = 1'b1;
        if (cur_r.op == OP_DRAW) begin
          e_bin = BIN_W'(hit_idx_r);
          if (hist_sat) begin
            e_cnt = hist_q;
            e_st  = ST_SAT;
          end else begin
            hist_we = 1'b1;
            e_cnt   = hist_wdata;
          end
        end else begin
          e_cnt = cur_r.bin_ok ? hist_q : '0;
        end
      end
      B_HCLR: begin
        hist_we    = 1'b1;
        hist_waddr = clr_r[BW-1:0];
        hist_wdata = '0;
        clr_nxt    = clr_r + 1'b1;
        if (clr_r == WA'(BINS - 1)) emit = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    cur_r     <= cur_nxt;
    rd_idx_r  <= rd_idx_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    left_r    <= left_nxt;
    point_r   <= point_nxt;
    p_lo_r    <= p_lo_nxt;
    hit_idx_r <= hit_idx_nxt;
    if (emit) begin
      out_hit_bin_r     <= e_bin;
      out_count_value_r <= e_cnt;
      out_status_r      <= e_st;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= B_INIT;
      clr_r        <= '0;
      dv_r         <= 1'b0;
      out_strobe_r <= 1'b0;
      for (int i = 0; i < SPECTRA; i++) begin
        total_r[i] <= '0;
      end
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      dv_r         <= dv_nxt;
      out_strobe_r <= emit;
      if (tot_we) begin
        total_r[spec_idx] <= tot_wdata;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/core/weighted_spectrum_sampler.sv]
// A draw walks the bins, reading one stored weight per cycle from the weight RAM.
// One transaction is executed at a time; a 2-entry command queue takes new commands meanwhile.
// After rst_n the weight store and histogram are swept to zero, with busy held high.
// Results are strobed for one cycle; the receiver cannot stall.
`default_nettype none
module weighted_spectrum_sampler #(
  parameter int BINS        = 1024,
  parameter int SPECTRA     = 4,
  parameter int WEIGHT_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [wss_pkg::OP_W-1:0]      in_opcode,
  input  wire logic [wss_pkg::SPEC_W-1:0]    in_spectrum_sel,
  input  wire logic [wss_pkg::BIN_W-1:0]     in_bin_sel,
  input  wire logic [wss_pkg::WEIGHT_W-1:0]  in_bin_weight,
  input  wire logic [wss_pkg::FRAC_W-1:0]    in_random_fraction,
  output logic                               out_strobe,
  output logic [wss_pkg::BIN_W-1:0]          out_hit_bin,
  output logic [wss_pkg::COUNT_W-1:0]        out_count_value,
  output logic [wss_pkg::STATUS_W-1:0]       out_status
);
  import wss_pkg::*;

  logic  q_full, q_valid, q_pop, push, init_busy;
  item_t push_item, q_head;

  wss_front #(
    .BINS    (BINS),
    .SPECTRA (SPECTRA)
  ) u_front (
    .start              (start),
    .busy               (busy),
    .in_opcode          (in_opcode),
    .in_spectrum_sel    (in_spectrum_sel),
    .in_bin_sel         (in_bin_sel),
    .in_bin_weight      (in_bin_weight),
    .in_random_fraction (in_random_fraction),
    .q_full             (q_full),
    .init_busy          (init_busy),
    .push               (push),
    .push_item          (push_item)
  );

  wss_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  wss_back #(
    .BINS        (BINS),
    .SPECTRA     (SPECTRA),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_item          (q_head),
    .q_pop           (q_pop),
    .init_busy       (init_busy),
    .out_strobe      (out_strobe),
    .out_hit_bin     (out_hit_bin),
    .out_count_value (out_count_value),
    .out_status      (out_status)
  );

endmodule
`default_nettype wire
